// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL in this folder.
// Both expect signals named clock and reset in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define DDPC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define DDPC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/ddpc_pkg.sv =====
`default_nettype none

package ddpc_pkg;

   localparam int TIMER_BITS = 16;

   localparam int SENSOR_W = 12;
   localparam int ERR_W    = SENSOR_W + 1;
   localparam int GAIN_W   = 16;
   localparam int DUTY_W   = 8;
   localparam int PROD_W   = GAIN_W + ERR_W;
   localparam int ACC_W    = PROD_W + 2;

   localparam logic signed [DUTY_W-1:0] DUTY_MAX = 8'sd125;
   localparam logic signed [DUTY_W-1:0] DUTY_MIN = -8'sd125;

   typedef enum logic [3:0] {
      CSR_BASE_DUTY_LEFT        = 4'd0,
      CSR_BASE_DUTY_RIGHT       = 4'd1,
      CSR_TRACE_ENABLE          = 4'd2,
      CSR_GAIN_LEFT_FROM_LEFT   = 4'd3,
      CSR_GAIN_LEFT_FROM_RIGHT  = 4'd4,
      CSR_GAIN_RIGHT_FROM_LEFT  = 4'd5,
      CSR_GAIN_RIGHT_FROM_RIGHT = 4'd6,
      CSR_SENSOR_TARGET         = 4'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      FAULT_NONE  = 2'd0,
      FAULT_LEFT  = 2'd1,
      FAULT_RIGHT = 2'd2
   } fault_type;

   // Divides a Q8 accumulator by 256 toward zero and clamps to the duty range.
   function automatic logic signed [DUTY_W-1:0] duty_from_acc(
      input logic signed [ACC_W-1:0] acc
   );
      logic signed [ACC_W-1:0] quot;
      logic signed [DUTY_W-1:0] duty;
      quot = acc >>> 8;
      if (acc[ACC_W-1] && (acc[7:0] != 8'd0)) begin
         quot = quot + ACC_W'(1);
      end
      if (quot > ACC_W'(DUTY_MAX)) begin
         duty = DUTY_MAX;
      end else if (quot < ACC_W'(DUTY_MIN)) begin
         duty = DUTY_MIN;
      end else begin
         duty = quot[DUTY_W-1:0];
      end
      return duty;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/differential_drive_p_control_tick.sv =====
// A transaction accepted into the input register has its result registered in the result
// register once that register is free.
// Throughput: one transaction per cycle unless rsp_stall holds the result; the gain products, sum,
// clamp, echo check and countdown all sit between the input register and the result register.
// Reset clears the input and result valids, the last drives, the fault code and the
// countdown, and returns the control registers to their defaults (base duties 100, rest zero).
`default_nettype none
`include "assert_macros.svh"

module differential_drive_p_control_tick (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [11:0] req_sensor_left,
   input  wire logic [11:0] req_sensor_right,
   input  wire logic signed [7:0] req_echo_left,
   input  wire logic signed [7:0] req_echo_right,
   input  wire logic        req_load_timer,
   input  wire logic [15:0] req_timer_value,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [7:0] rsp_drive_left,
   output logic signed [7:0] rsp_drive_right,
   output logic [1:0]       rsp_error_code,
   output logic [15:0]      rsp_timer_count,
   output logic             rsp_timer_expired,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int TB  = ddpc_pkg::TIMER_BITS;
   localparam int PW  = ddpc_pkg::PROD_W;
   localparam int AW  = ddpc_pkg::ACC_W;
   localparam int EW  = ddpc_pkg::ERR_W;

   // Control registers.
   logic signed [7:0]  base_left_ff;
   logic signed [7:0]  base_right_ff;
   logic               trace_ff;
   logic signed [15:0] gain_ll_ff;
   logic signed [15:0] gain_lr_ff;
   logic signed [15:0] gain_rl_ff;
   logic signed [15:0] gain_rr_ff;
   logic [11:0]        target_ff;

   // Input stage.
   logic               a_valid_ff;
   logic [11:0]        a_sensor_left_ff;
   logic [11:0]        a_sensor_right_ff;
   logic [7:0]         a_echo_left_ff;
   logic [7:0]         a_echo_right_ff;
   logic               a_load_ff;
   logic [15:0]        a_tval_ff;

   // Per-tick state.
   logic [7:0]         last_left_ff;
   logic [7:0]         last_right_ff;
   ddpc_pkg::fault_type fault_ff;
   ddpc_pkg::fault_type fault_in;
   logic [TB-1:0]      tick_ff;
   logic [TB-1:0]      tick_sel;
   logic [TB-1:0]      tick_in;

   // Result register.
   logic               rsp_valid_ff;
   logic signed [7:0]  rsp_drive_left_ff;
   logic signed [7:0]  rsp_drive_right_ff;
   logic [1:0]         rsp_error_code_ff;
   logic [15:0]        rsp_timer_count_ff;
   logic               rsp_timer_expired_ff;

   logic               out_free;
   logic               a_adv;
   logic               a_free;
   logic               req_take;

   logic signed [EW-1:0] err_left;
   logic signed [EW-1:0] err_right;
   logic signed [PW-1:0] prod_ll;
   logic signed [PW-1:0] prod_lr;
   logic signed [PW-1:0] prod_rl;
   logic signed [PW-1:0] prod_rr;
   logic signed [AW-1:0] acc_left;
   logic signed [AW-1:0] acc_right;
   logic signed [7:0]    drive_left;
   logic signed [7:0]    drive_right;

   logic               fault_set;
   logic               rsp_in_range;

   // Handshake: each stage moves on when the one after it is empty or moving.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign a_adv     = a_valid_ff && out_free;
   assign a_free    = !a_valid_ff || a_adv;
   assign req_stall = !a_free;
   assign req_take  = req_valid && a_free;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_left_ff  <= 8'sd100;
         base_right_ff <= 8'sd100;
         trace_ff      <= 1'b0;
         gain_ll_ff    <= '0;
         gain_lr_ff    <= '0;
         gain_rl_ff    <= '0;
         gain_rr_ff    <= '0;
         target_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (ddpc_pkg::csr_index_type'(csr_index))
            ddpc_pkg::CSR_BASE_DUTY_LEFT:        base_left_ff  <= csr_data[7:0];
            ddpc_pkg::CSR_BASE_DUTY_RIGHT:       base_right_ff <= csr_data[7:0];
            ddpc_pkg::CSR_TRACE_ENABLE:          trace_ff      <= csr_data[0];
            ddpc_pkg::CSR_GAIN_LEFT_FROM_LEFT:   gain_ll_ff    <= csr_data;
            ddpc_pkg::CSR_GAIN_LEFT_FROM_RIGHT:  gain_lr_ff    <= csr_data;
            ddpc_pkg::CSR_GAIN_RIGHT_FROM_LEFT:  gain_rl_ff    <= csr_data;
            ddpc_pkg::CSR_GAIN_RIGHT_FROM_RIGHT: gain_rr_ff    <= csr_data;
            ddpc_pkg::CSR_SENSOR_TARGET:         target_ff     <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   // Input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_free) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_sensor_left_ff  <= req_sensor_left;
         a_sensor_right_ff <= req_sensor_right;
         a_echo_left_ff    <= req_echo_left;
         a_echo_right_ff   <= req_echo_right;
         a_load_ff         <= req_load_timer;
         a_tval_ff         <= req_timer_value;
      end
   end

   // Sensor errors, gain products, sum, clamp, echo check and countdown.
   always_comb begin
      err_left  = $signed({1'b0, a_sensor_left_ff}) - $signed({1'b0, target_ff});
      err_right = $signed({1'b0, a_sensor_right_ff}) - $signed({1'b0, target_ff});
      prod_ll   = gain_ll_ff * err_left;
      prod_lr   = gain_lr_ff * err_right;
      prod_rl   = gain_rl_ff * err_left;
      prod_rr   = gain_rr_ff * err_right;

      acc_left  = {{(AW-16){base_left_ff[7]}}, base_left_ff, 8'h00}
                  - AW'(prod_ll) - AW'(prod_lr);
      acc_right = {{(AW-16){base_right_ff[7]}}, base_right_ff, 8'h00}
                  - AW'(prod_rl) - AW'(prod_rr);
      if (trace_ff) begin
         drive_left  = ddpc_pkg::duty_from_acc(acc_left);
         drive_right = ddpc_pkg::duty_from_acc(acc_right);
      end else begin
         drive_left  = base_left_ff;
         drive_right = base_right_ff;
      end

      // A right mismatch overrides a left one on the same tick.
      if (a_echo_right_ff != last_right_ff) begin
         fault_in = ddpc_pkg::FAULT_RIGHT;
      end else if (a_echo_left_ff != last_left_ff) begin
         fault_in = ddpc_pkg::FAULT_LEFT;
      end else begin
         fault_in = fault_ff;
      end

      tick_sel = a_load_ff ? TB'(a_tval_ff) : tick_ff;
      if (tick_sel != '0) begin
         tick_in = tick_sel - TB'(1);
      end else begin
         tick_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_left_ff  <= '0;
         last_right_ff <= '0;
         fault_ff      <= ddpc_pkg::FAULT_NONE;
         tick_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= a_valid_ff;
         end
         if (a_adv) begin
            last_left_ff  <= drive_left;
            last_right_ff <= drive_right;
            fault_ff      <= fault_in;
            tick_ff       <= tick_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         rsp_drive_left_ff    <= drive_left;
         rsp_drive_right_ff   <= drive_right;
         rsp_error_code_ff    <= fault_in;
         rsp_timer_count_ff   <= 16'(tick_in);
         rsp_timer_expired_ff <= (tick_in == '0);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_left    = rsp_drive_left_ff;
   assign rsp_drive_right   = rsp_drive_right_ff;
   assign rsp_error_code    = rsp_error_code_ff;
   assign rsp_timer_count   = rsp_timer_count_ff;
   assign rsp_timer_expired = rsp_timer_expired_ff;

   assign fault_set    = (fault_ff != ddpc_pkg::FAULT_NONE);
   assign rsp_in_range = (rsp_drive_left >= ddpc_pkg::DUTY_MIN)
                         && (rsp_drive_left <= ddpc_pkg::DUTY_MAX)
                         && (rsp_drive_right >= ddpc_pkg::DUTY_MIN)
                         && (rsp_drive_right <= ddpc_pkg::DUTY_MAX);

   `DDPC_ASSERT_ALWAYS(a_reset_empties_output, reset |=> !rsp_valid, "result valid after reset")
   `DDPC_ASSERT(a_fault_sticky, fault_set |=> fault_set, "fault code cleared")
   `DDPC_ASSERT(a_input_not_lost, a_valid_ff && !a_adv |=> a_valid_ff, "input dropped")
   `DDPC_ASSERT(a_traced_drive_clamped, a_adv && trace_ff |=> rsp_in_range, "drive unclamped")

endmodule

`default_nettype wire

// ===== verif/differential_drive_p_control_tick_tb.sv =====
`default_nettype none

module differential_drive_p_control_tick_tb;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int CSR_COUNT      = 8;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_TICKS    = 218;
   localparam int TIMER_W        = ddpc_pkg::TIMER_BITS;

   typedef struct packed {
      logic [11:0]       sensor_left;
      logic [11:0]       sensor_right;
      logic signed [7:0] echo_left;
      logic signed [7:0] echo_right;
      logic              load_timer;
      logic [15:0]       timer_value;
   } tick_type;

   typedef struct packed {
      logic signed [7:0]   drive_left;
      logic signed [7:0]   drive_right;
      ddpc_pkg::fault_type error_code;
      logic [15:0]         timer_count;
      logic                timer_expired;
   } drive_type;

   // Tracks the controller registers and tick state, and holds the drives
   // that are still owed by the block.
   class drive_scoreboard_type;
      logic signed [7:0]   base_left;
      logic signed [7:0]   base_right;
      logic                trace_on;
      logic signed [15:0]  gain_ll;
      logic signed [15:0]  gain_lr;
      logic signed [15:0]  gain_rl;
      logic signed [15:0]  gain_rr;
      logic [11:0]         target;
      logic signed [7:0]   last_left;
      logic signed [7:0]   last_right;
      ddpc_pkg::fault_type fault;
      logic [TIMER_W-1:0]  countdown;
      drive_type           expected_drives[$];
      int                  failures;

      function new();
         base_left  = 8'sd100;
         base_right = 8'sd100;
         trace_on   = 1'b0;
         gain_ll    = '0;
         gain_lr    = '0;
         gain_rl    = '0;
         gain_rr    = '0;
         target     = '0;
         last_left  = '0;
         last_right = '0;
         fault      = ddpc_pkg::FAULT_NONE;
         countdown  = '0;
         failures   = 0;
      endfunction

      function void write_register(logic [3:0] index, logic [15:0] data);
         case (index)
            ddpc_pkg::CSR_BASE_DUTY_LEFT:        base_left  = data[7:0];
            ddpc_pkg::CSR_BASE_DUTY_RIGHT:       base_right = data[7:0];
            ddpc_pkg::CSR_TRACE_ENABLE:          trace_on   = data[0];
            ddpc_pkg::CSR_GAIN_LEFT_FROM_LEFT:   gain_ll    = data;
            ddpc_pkg::CSR_GAIN_LEFT_FROM_RIGHT:  gain_lr    = data;
            ddpc_pkg::CSR_GAIN_RIGHT_FROM_LEFT:  gain_rl    = data;
            ddpc_pkg::CSR_GAIN_RIGHT_FROM_RIGHT: gain_rr    = data;
            ddpc_pkg::CSR_SENSOR_TARGET:         target     = data[11:0];
            default: ;
         endcase
      endfunction

      // Exact Q8 sum, divided toward zero, then clamped to the duty range.
      function logic signed [7:0] corrected_duty(logic signed [7:0] base,
                                                 logic signed [15:0] gain_a,
                                                 logic signed [15:0] gain_b,
                                                 int err_left, int err_right);
         longint acc;
         longint quot;
         acc = longint'(base) * 256 - longint'(gain_a) * err_left
               - longint'(gain_b) * err_right;
         quot = acc / 256;
         if (quot > longint'(ddpc_pkg::DUTY_MAX)) quot = longint'(ddpc_pkg::DUTY_MAX);
         if (quot < longint'(ddpc_pkg::DUTY_MIN)) quot = longint'(ddpc_pkg::DUTY_MIN);
         return quot[7:0];
      endfunction

      function void note_tick(tick_type t);
         drive_type d;
         int        err_left;
         int        err_right;
         d.drive_left  = base_left;
         d.drive_right = base_right;
         if (trace_on) begin
            err_left      = int'(t.sensor_left) - int'(target);
            err_right     = int'(t.sensor_right) - int'(target);
            d.drive_left  = corrected_duty(base_left, gain_ll, gain_lr, err_left, err_right);
            d.drive_right = corrected_duty(base_right, gain_rl, gain_rr, err_left, err_right);
         end
         if (t.echo_left != last_left) fault = ddpc_pkg::FAULT_LEFT;
         if (t.echo_right != last_right) fault = ddpc_pkg::FAULT_RIGHT;
         last_left  = d.drive_left;
         last_right = d.drive_right;
         if (t.load_timer) countdown = TIMER_W'(t.timer_value);
         if (countdown != 0) countdown = countdown - 1'b1;
         d.error_code    = fault;
         d.timer_count   = 16'(countdown);
         d.timer_expired = (countdown == 0);
         expected_drives.push_back(d);
      endfunction

      function void check_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_drive(drive_type got);
         drive_type want;
         if (expected_drives.size() == 0) begin
            $display("%0t unexpected result: expected none, actual drives %0d/%0d",
                     $time, got.drive_left, got.drive_right);
            failures++;
         end else begin
            want = expected_drives.pop_front();
            check_field("drive_left", want.drive_left, got.drive_left);
            check_field("drive_right", want.drive_right, got.drive_right);
            check_field("error_code", int'(want.error_code), int'(got.error_code));
            check_field("timer_count", want.timer_count, got.timer_count);
            check_field("timer_expired", want.timer_expired, got.timer_expired);
         end
      endfunction

      function int pending();
         return expected_drives.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic [11:0]       req_sensor_left  = '0;
   logic [11:0]       req_sensor_right = '0;
   logic signed [7:0] req_echo_left    = '0;
   logic signed [7:0] req_echo_right   = '0;
   logic              req_load_timer   = 1'b0;
   logic [15:0]       req_timer_value  = '0;

   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic signed [7:0] rsp_drive_left;
   logic signed [7:0] rsp_drive_right;
   logic [1:0]        rsp_error_code;
   logic [15:0]       rsp_timer_count;
   logic              rsp_timer_expired;

   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [3:0]        csr_index = '0;
   logic [15:0]       csr_data  = '0;

   drive_scoreboard_type sb = new();
   logic                 steady = 1'b0;
   int                   idle_cycles = 0;

   differential_drive_p_control_tick dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sensor_left   (req_sensor_left),
      .req_sensor_right  (req_sensor_right),
      .req_echo_left     (req_echo_left),
      .req_echo_right    (req_echo_right),
      .req_load_timer    (req_load_timer),
      .req_timer_value   (req_timer_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_drive_left    (rsp_drive_left),
      .rsp_drive_right   (rsp_drive_right),
      .rsp_error_code    (rsp_error_code),
      .rsp_timer_count   (rsp_timer_count),
      .rsp_timer_expired (rsp_timer_expired),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !steady && ($urandom_range(0, 99) < 18);
      end
   end

   always @(posedge clock) begin
      drive_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.drive_left    = rsp_drive_left;
         got.drive_right   = rsp_drive_right;
         got.error_code    = ddpc_pkg::fault_type'(rsp_error_code);
         got.timer_count   = rsp_timer_count;
         got.timer_expired = rsp_timer_expired;
         sb.check_drive(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_csr(input logic [3:0] index, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Presents one tick, optionally after a few idle cycles, and records it
   // in the scoreboard at the edge where it is accepted.
   task automatic send_tick(input tick_type t, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sensor_left  <= t.sensor_left;
      req_sensor_right <= t.sensor_right;
      req_echo_left    <= t.echo_left;
      req_echo_right   <= t.echo_right;
      req_load_timer   <= t.load_timer;
      req_timer_value  <= t.timer_value;
      do @(posedge clock); while (req_stall);
      sb.note_tick(t);
   endtask

   // Waits until every owed drive has come back, so registers can be written.
   task automatic settle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // A gap is drawn for about six ticks in a hundred, and never while steady is set.
   function automatic int idle_gap();
      if (steady || $urandom_range(0, 99) >= 6) return 0;
      return $urandom_range(1, 6);
   endfunction

   // A tick whose echoes match the drives sent on the previous tick.
   function automatic tick_type clean_tick(logic [11:0] left, logic [11:0] right,
                                           logic load, logic [15:0] value);
      tick_type t;
      t.sensor_left  = left;
      t.sensor_right = right;
      t.echo_left    = sb.last_left;
      t.echo_right   = sb.last_right;
      t.load_timer   = load;
      t.timer_value  = value;
      return t;
   endfunction

   function automatic logic [7:0] bad_echo(logic [7:0] good);
      return good ^ 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [11:0] random_sensor();
      int v;
      if ($urandom_range(0, 99) >= 60) return 12'($urandom_range(0, 4095));
      v = int'(sb.target) + int'($urandom_range(0, 400)) - 200;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return 12'(v);
   endfunction

   function automatic tick_type random_tick(int fault_pct);
      tick_type t;
      t = clean_tick(random_sensor(), random_sensor(), $urandom_range(0, 99) < 8,
                     ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 40))
                                                  : 16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 99) < fault_pct) t.echo_left = bad_echo(t.echo_left);
      if ($urandom_range(0, 99) < fault_pct) t.echo_right = bad_echo(t.echo_right);
      return t;
   endfunction

   function automatic logic [15:0] random_gain();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 16'($urandom_range(0, 512) - 256);
      if (roll < 80) return 16'($urandom_range(0, 4096) - 2048);
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [15:0] random_base();
      int b;
      if ($urandom_range(0, 99) < 85) begin
         b = int'($urandom_range(0, 250)) - 125;
      end else begin
         b = int'($urandom_range(0, 255)) - 128;
      end
      return {8'($urandom_range(0, 255)), 8'(b)};
   endfunction

   task automatic random_config();
      int roll;
      roll = $urandom_range(0, 9);
      write_csr(ddpc_pkg::CSR_BASE_DUTY_LEFT, random_base());
      write_csr(ddpc_pkg::CSR_BASE_DUTY_RIGHT, random_base());
      write_csr(ddpc_pkg::CSR_TRACE_ENABLE, {15'($urandom_range(0, 32767)), roll < 8});
      write_csr(ddpc_pkg::CSR_GAIN_LEFT_FROM_LEFT, random_gain());
      write_csr(ddpc_pkg::CSR_GAIN_LEFT_FROM_RIGHT, random_gain());
      write_csr(ddpc_pkg::CSR_GAIN_RIGHT_FROM_LEFT, random_gain());
      write_csr(ddpc_pkg::CSR_GAIN_RIGHT_FROM_RIGHT, random_gain());
      write_csr(ddpc_pkg::CSR_SENSOR_TARGET, 16'($urandom_range(0, 65535)));
   endtask

   initial begin
      tick_type t;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Defaults after reset: tracing off, both base duties at 100.
      // The countdown is loaded, runs out, holds at zero, and is loaded with its largest value.
      send_tick(clean_tick(12'h000, 12'h000, 1'b1, 16'd3), 0);
      send_tick(clean_tick(12'hFFF, 12'hFFF, 1'b0, 16'hFFFF), 0);
      send_tick(clean_tick(12'h000, 12'hFFF, 1'b0, 16'h0000), 0);
      send_tick(clean_tick(12'hFFF, 12'h000, 1'b0, 16'h0000), 0);
      send_tick(clean_tick(12'h555, 12'hAAA, 1'b1, 16'hFFFF), 0);
      send_tick(clean_tick(12'hAAA, 12'h555, 1'b1, 16'h0000), 0);
      req_valid <= 1'b0;
      settle();

      // Out-of-range base duties pass unchanged while tracing is off. The
      // writes to unused indices must leave every register alone.
      write_csr(ddpc_pkg::CSR_BASE_DUTY_LEFT, 16'hFF80);
      write_csr(ddpc_pkg::CSR_BASE_DUTY_RIGHT, 16'h007F);
      write_csr(4'(CSR_COUNT), 16'h0000);
      write_csr(4'($urandom_range(CSR_COUNT, 15)), 16'h0001);
      send_tick(clean_tick(12'h123, 12'h321, 1'b0, 16'h0000), 0);
      send_tick(clean_tick(12'hFFF, 12'h000, 1'b0, 16'h0000), 0);
      req_valid <= 1'b0;
      settle();

      // Tracing on with zero gains only clamps the base duties.
      write_csr(ddpc_pkg::CSR_TRACE_ENABLE, 16'h0001);
      send_tick(clean_tick(12'h000, 12'h000, 1'b0, 16'h0000), 0);
      send_tick(clean_tick(12'hFFF, 12'hFFF, 1'b0, 16'h0000), 0);
      req_valid <= 1'b0;
      settle();

      // Extreme gains and target drive the accumulator to both ends.
      write_csr(ddpc_pkg::CSR_BASE_DUTY_LEFT, 16'h007D);
      write_csr(ddpc_pkg::CSR_BASE_DUTY_RIGHT, 16'h0083);
      write_csr(ddpc_pkg::CSR_GAIN_LEFT_FROM_LEFT, 16'h7FFF);
      write_csr(ddpc_pkg::CSR_GAIN_LEFT_FROM_RIGHT, 16'h8000);
      write_csr(ddpc_pkg::CSR_GAIN_RIGHT_FROM_LEFT, 16'h8000);
      write_csr(ddpc_pkg::CSR_GAIN_RIGHT_FROM_RIGHT, 16'h7FFF);
      write_csr(ddpc_pkg::CSR_SENSOR_TARGET, 16'h0FFF);
      send_tick(clean_tick(12'h000, 12'h000, 1'b0, 16'h0000), 0);
      send_tick(clean_tick(12'hFFF, 12'hFFF, 1'b0, 16'h0000), 0);
      send_tick(clean_tick(12'h000, 12'hFFF, 1'b0, 16'h0000), 0);
      send_tick(clean_tick(12'hFFF, 12'h000, 1'b0, 16'h0000), 0);
      req_valid <= 1'b0;
      settle();

      // Small gains around a mid target: a tiny negative sum must truncate
      // to zero rather than round down to -1.
      write_csr(ddpc_pkg::CSR_BASE_DUTY_LEFT, 16'h0000);
      write_csr(ddpc_pkg::CSR_BASE_DUTY_RIGHT, 16'h0000);
      write_csr(ddpc_pkg::CSR_GAIN_LEFT_FROM_LEFT, 16'h0100);
      write_csr(ddpc_pkg::CSR_GAIN_LEFT_FROM_RIGHT, 16'hFF80);
      write_csr(ddpc_pkg::CSR_GAIN_RIGHT_FROM_LEFT, 16'h0003);
      write_csr(ddpc_pkg::CSR_GAIN_RIGHT_FROM_RIGHT, 16'hFFFB);
      write_csr(ddpc_pkg::CSR_SENSOR_TARGET, 16'h0800);
      send_tick(clean_tick(12'h801, 12'h800, 1'b0, 16'h0000), 0);
      send_tick(clean_tick(12'h7FF, 12'h800, 1'b0, 16'h0000), 0);
      send_tick(clean_tick(12'h800, 12'h801, 1'b0, 16'h0000), 0);
      send_tick(clean_tick(12'h864, 12'h79C, 1'b0, 16'h0000), 0);
      req_valid <= 1'b0;

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         random_config();
         steady <= (p == 4);
         if (p == 2) begin
            // The first echo mismatches: left alone, then right alone, left
            // again to show the last one wins, then both, where right wins.
            t = random_tick(0);
            t.echo_left = bad_echo(t.echo_left);
            send_tick(t, 0);
            send_tick(random_tick(0), 0);
            t = random_tick(0);
            t.echo_right = bad_echo(t.echo_right);
            send_tick(t, 0);
            t = random_tick(0);
            t.echo_left = bad_echo(t.echo_left);
            send_tick(t, 0);
            t = random_tick(0);
            t.echo_left  = bad_echo(t.echo_left);
            t.echo_right = bad_echo(t.echo_right);
            send_tick(t, 0);
         end
         // Early phases keep the echoes clean so the fault code stays clear.
         for (int i = 0; i < PHASE_TICKS; i++) begin
            send_tick(random_tick((p < 2) ? 0 : 12), idle_gap());
         end
         req_valid <= 1'b0;
      end

      settle();
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
